@@ rtl/bpuf_pkg.sv @@
// Package for the bond percolation union-find block.
// Holds lattice defaults, bond direction codes, fixed port widths and divide-by-three constants; no dependencies.
package bpuf_pkg;

	localparam int unsigned SIDE_DEF = 256;

	localparam int unsigned BOND_W = 18;
	localparam int unsigned SIZE_W = 17;
	localparam int unsigned ROOT_W = 16;

	localparam logic [1:0] DIR_RIGHT     = 2'd0;
	localparam logic [1:0] DIR_DOWN      = 2'd1;
	localparam logic [1:0] DIR_DOWN_LEFT = 2'd2;

	// Reciprocal of three for an exact quotient of an 18-bit bond index.
	localparam int unsigned DIV3_SHIFT = 20;
	localparam logic [18:0] DIV3_MUL = 19'd349526;

endpackage

@@ rtl/bpuf_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bpuf_ram #(
	parameter int unsigned WIDTH = 17,
	parameter int unsigned DEPTH = 65536,
	parameter int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/bpuf_addr.sv @@
// Bond decoder: splits a bond index into its two lattice sites over five stages.
// Depends on bpuf_pkg.
module bpuf_addr #(
	parameter int unsigned SIDE = bpuf_pkg::SIDE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic [bpuf_pkg::BOND_W-1:0]     bond,
	output logic                            out_valid,
	output logic                            ok,
	output logic [$clog2(SIDE*SIDE)-1:0]    site_a,
	output logic [$clog2(SIDE*SIDE)-1:0]    site_b
);

	localparam int unsigned SITES = SIDE * SIDE;
	localparam int unsigned AW = $clog2(SITES);
	localparam int unsigned SW = $clog2(SIDE);
	localparam int unsigned BONDS = 3 * SITES;
	localparam int unsigned KS = AW + 2 * SW;
	localparam longint unsigned MS = ((64'd1 << KS) + SIDE - 1) / SIDE;
	localparam int unsigned MSW = KS - SW + 2;
	localparam logic [MSW-1:0] MS_C = MSW'(MS);
	localparam logic [AW:0] SITES_W = (AW + 1)'(SITES);
	localparam logic [AW:0] SIDE_W = (AW + 1)'(SIDE);
	localparam logic [AW-1:0] SIDE_A = AW'(SIDE);
	localparam logic [AW-1:0] LAST_COL = AW'(SIDE - 1);

	logic [4:0] vld_q;

	logic [36:0] prod3_s1;
	logic [17:0] bond_s1;
	logic [16:0] quot;
	logic [17:0] rem_w;

	logic [AW-1:0] s1_s2, s1_s3, s1_s4;
	logic [1:0] dir_s2, dir_s3, dir_s4;
	logic ok_s2, ok_s3, ok_s4;
	logic [AW+MSW-1:0] rowprod_s3;
	logic [AW-1:0] row;
	logic [AW-1:0] col_s4;

	logic [AW:0] s1x, t_right, t_down, t_dl, t_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[3:0], in_valid};
		end
	end

	assign quot = prod3_s1[36:20];
	assign rem_w = bond_s1 - {quot, 1'b0} - 18'(quot);
	assign row = AW'(rowprod_s3 >> KS);

	assign s1x = {1'b0, s1_s4};
	assign t_right = (col_s4 == LAST_COL) ? (s1x + 1'b1 - SIDE_W) : (s1x + 1'b1);
	assign t_down = s1x + SIDE_W;
	assign t_dl = (col_s4 == '0) ? (s1x + {SIDE_W[AW-1:0], 1'b0} - 1'b1)
		: (s1x + SIDE_W - 1'b1);

	always_comb begin
		case (dir_s4)
			bpuf_pkg::DIR_RIGHT: t_sel = t_right;
			bpuf_pkg::DIR_DOWN:  t_sel = t_down;
			default:             t_sel = t_dl;
		endcase
	end

	always_ff @(posedge clk) begin
		prod3_s1 <= 37'(bond) * 37'(bpuf_pkg::DIV3_MUL);
		bond_s1 <= bond;

		s1_s2 <= AW'(quot);
		dir_s2 <= rem_w[1:0];
		ok_s2 <= (32'(bond_s1) < BONDS);

		rowprod_s3 <= (AW + MSW)'(s1_s2) * (AW + MSW)'(MS_C);
		s1_s3 <= s1_s2;
		dir_s3 <= dir_s2;
		ok_s3 <= ok_s2;

		col_s4 <= s1_s3 - AW'(row * SIDE_A);
		s1_s4 <= s1_s3;
		dir_s4 <= dir_s3;
		ok_s4 <= ok_s3;

		site_a <= s1_s4;
		site_b <= (t_sel >= SITES_W) ? AW'(t_sel - SITES_W) : AW'(t_sel);
		ok <= ok_s4;
	end

	assign out_valid = vld_q[4];

endmodule

@@ rtl/bond_percolation_union_find.sv @@
// Top level of the bond percolation union-find block: sequencer and forest memory.
// Depends on bpuf_pkg, bpuf_ram and bpuf_addr.
//
// Usage: raise start with req_type and bond_index while busy is low; the request is
// taken at that edge. req_type 0 occupies a bond, req_type 1 runs the spanning check.
// Every request gives exactly one result: done is high for one cycle while merged,
// largest_size, largest_root and spans show it. The receiver cannot stall; results
// are never held back, and busy drops in the cycle that the result beat is driven.
// An add runs the bond through the bpuf_addr decoder, then a forest read (ST_RD,
// then ST_CHK) per node along both root walks (union by size keeps each walk to at
// most log2 of the site count plus one reads); on a merge ST_WIN writes the new size
// and ST_LOSE links the losing root, and ST_DONE registers the result. A query walks
// to the root from each site of row 0 and, if row 0 touched the largest cluster, of
// row SIDE/2; once the spanning flag is set a query goes straight to the result.
// After reset the block clears the forest, one site per cycle, all SIDE*SIDE sites,
// with busy high; requests are taken afterwards.
module bond_percolation_union_find #(
	parameter int unsigned SIDE = bpuf_pkg::SIDE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            req_type,
	input  logic [bpuf_pkg::BOND_W-1:0]     bond_index,
	output logic                            done,
	output logic                            merged,
	output logic [bpuf_pkg::SIZE_W-1:0]     largest_size,
	output logic [bpuf_pkg::ROOT_W-1:0]     largest_root,
	output logic                            spans
);

	localparam int unsigned SITES = SIDE * SIDE;
	localparam int unsigned AW = $clog2(SITES);
	localparam int unsigned DW = AW + 1;
	localparam int unsigned SW = $clog2(SIDE);
	localparam logic [AW-1:0] LAST_SITE = AW'(SITES - 1);
	localparam logic [AW-1:0] HALF_BASE = AW'((SIDE / 2) * SIDE);
	localparam logic [SW-1:0] LAST_COL = SW'(SIDE - 1);

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_DEC  = 4'd2;
	localparam logic [3:0] ST_RD   = 4'd3;
	localparam logic [3:0] ST_CHK  = 4'd4;
	localparam logic [3:0] ST_WIN  = 4'd5;
	localparam logic [3:0] ST_LOSE = 4'd6;
	localparam logic [3:0] ST_DONE = 4'd7;

	logic [3:0] state_q;
	logic [AW-1:0] clr_q;
	logic query_q, phase_q, merged_q, span_q, row_half_q, hit_q;
	logic [AW-1:0] cur_q, s2_q, r1_q, r2_q, win_q, lose_q;
	logic [DW-1:0] v1_q, v2_q;
	logic [SW-1:0] col_q;
	logic [DW-1:0] top_size_q;
	logic [AW-1:0] top_root_q;

	logic dec_valid, dec_ok;
	logic [AW-1:0] dec_a, dec_b;
	logic accept;

	logic ram_we, ram_re;
	logic [AW-1:0] ram_waddr;
	logic [DW-1:0] ram_wdata, ram_rdata;

	logic win_is_r2;
	logic [AW-1:0] win_sel, lose_sel;
	logic [DW-1:0] sum;
	logic [DW-1:0] new_size;
	logic hit_now;
	logic [AW-1:0] next_site;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;

	bpuf_addr #(.SIDE(SIDE)) u_addr (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept && !req_type),
		.bond      (bond_index),
		.out_valid (dec_valid),
		.ok        (dec_ok),
		.site_a    (dec_a),
		.site_b    (dec_b)
	);

	bpuf_ram #(.WIDTH(DW), .DEPTH(SITES)) u_forest (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (cur_q),
		.rdata (ram_rdata)
	);

	// Larger entry means smaller cluster; on a tie the first root wins.
	assign win_is_r2 = ($signed(v1_q) > $signed(v2_q));
	assign win_sel = win_is_r2 ? r2_q : r1_q;
	assign lose_sel = win_is_r2 ? r1_q : r2_q;
	assign sum = v1_q + v2_q;
	assign new_size = -sum;

	assign hit_now = hit_q || (cur_q == top_root_q);
	assign next_site = (row_half_q ? HALF_BASE : '0) + AW'(col_q) + 1'b1;

	assign ram_re = (state_q == ST_RD);

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '1;
		case (state_q)
			ST_CLR: begin
				ram_we = 1'b1;
			end
			ST_WIN: begin
				ram_we = 1'b1;
				ram_waddr = win_sel;
				ram_wdata = sum;
			end
			ST_LOSE: begin
				ram_we = 1'b1;
				ram_waddr = lose_q;
				ram_wdata = {1'b0, win_q};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			top_size_q <= DW'(1);
			top_root_q <= '0;
			span_q <= 1'b0;
			done <= 1'b0;
			merged_q <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_SITE) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						merged_q <= 1'b0;
						if (!req_type) begin
							state_q <= ST_DEC;
						end else if (span_q) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_DEC: begin
					if (dec_valid) begin
						state_q <= dec_ok ? ST_RD : ST_DONE;
					end
				end
				ST_RD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (!ram_rdata[DW-1]) begin
						state_q <= ST_RD;
					end else if (!query_q) begin
						if (!phase_q) begin
							state_q <= ST_RD;
						end else begin
							state_q <= (cur_q == r1_q) ? ST_DONE : ST_WIN;
						end
					end else if (col_q == LAST_COL) begin
						if (!row_half_q && hit_now) begin
							state_q <= ST_RD;
						end else begin
							if (row_half_q) begin
								span_q <= hit_now;
							end
							state_q <= ST_DONE;
						end
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_WIN: begin
					if (new_size > top_size_q) begin
						top_size_q <= new_size;
						top_root_q <= win_sel;
					end
					state_q <= ST_LOSE;
				end
				ST_LOSE: begin
					merged_q <= 1'b1;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					done <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Walk, scan, merge and result datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				query_q <= req_type;
				phase_q <= 1'b0;
				col_q <= '0;
				row_half_q <= 1'b0;
				hit_q <= 1'b0;
				cur_q <= '0;
			end
			ST_DEC: begin
				cur_q <= dec_a;
				s2_q <= dec_b;
			end
			ST_CHK: begin
				if (!ram_rdata[DW-1]) begin
					cur_q <= ram_rdata[AW-1:0];
				end else if (!query_q) begin
					if (!phase_q) begin
						r1_q <= cur_q;
						v1_q <= ram_rdata;
						phase_q <= 1'b1;
						cur_q <= s2_q;
					end else begin
						r2_q <= cur_q;
						v2_q <= ram_rdata;
					end
				end else if (col_q == LAST_COL) begin
					// Move on to the middle row.
					row_half_q <= 1'b1;
					col_q <= '0;
					hit_q <= 1'b0;
					cur_q <= HALF_BASE;
				end else begin
					col_q <= col_q + 1'b1;
					hit_q <= hit_now;
					cur_q <= next_site;
				end
			end
			ST_WIN: begin
				win_q <= win_sel;
				lose_q <= lose_sel;
			end
			ST_DONE: begin
				merged <= merged_q;
				largest_size <= bpuf_pkg::SIZE_W'(top_size_q);
				largest_root <= bpuf_pkg::ROOT_W'(top_root_q);
				spans <= span_q;
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

endmodule
